/* hdl/pic_pkg.sv */
// Shared types, register map and helper functions of the interrupt controller.
package pic_pkg;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_ACK   = 2'd2,
		MODE_PIN   = 2'd3
	} mode_t;

	localparam logic [5:0] REG_COUNT = 6'd24;

	localparam logic [4:0] R_GPIP  = 5'd0;
	localparam logic [4:0] R_AER   = 5'd1;
	localparam logic [4:0] R_DDR   = 5'd2;
	localparam logic [4:0] R_IERA  = 5'd3;
	localparam logic [4:0] R_IERB  = 5'd4;
	localparam logic [4:0] R_IPRA  = 5'd5;
	localparam logic [4:0] R_IPRB  = 5'd6;
	localparam logic [4:0] R_ISRA  = 5'd7;
	localparam logic [4:0] R_ISRB  = 5'd8;
	localparam logic [4:0] R_IMRA  = 5'd9;
	localparam logic [4:0] R_IMRB  = 5'd10;
	localparam logic [4:0] R_VR    = 5'd11;
	localparam logic [4:0] R_TACR  = 5'd12;
	localparam logic [4:0] R_TBCR  = 5'd13;
	localparam logic [4:0] R_TCDCR = 5'd14;
	localparam logic [4:0] R_UCR   = 5'd20;

	// S bit of the vector register: software end-of-interrupt
	localparam int unsigned VR_S_BIT = 3;

	typedef logic [23:0][7:0] regfile_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] vector_out;
		logic       spurious;
		logic       irq_request;
	} result_t;

	typedef struct packed {
		logic       found;
		logic [3:0] ch;
	} pick_t;

	// Map a general purpose input pin onto its interrupt channel.
	function automatic logic [3:0] pin_channel(input logic [2:0] pin);
		logic [3:0] ch;
		case (pin)
			3'd4:    ch = 4'd6;
			3'd5:    ch = 4'd7;
			3'd6:    ch = 4'd14;
			3'd7:    ch = 4'd15;
			default: ch = {1'b0, pin};
		endcase
		return ch;
	endfunction

	// Highest pending, unmasked channel with no in-service bit at or above it.
	function automatic pick_t pick_channel(input regfile_t rf);
		logic [15:0] req;
		logic [15:0] svc;
		logic        blocked;
		logic        done;
		pick_t       pk;
		req     = {rf[R_IPRA], rf[R_IPRB]} & {rf[R_IMRA], rf[R_IMRB]};
		svc     = {rf[R_ISRA], rf[R_ISRB]};
		blocked = 1'b0;
		done    = 1'b0;
		pk      = '0;
		for (int i = 15; i >= 0; i--) begin
			blocked = blocked | svc[i];
			if (!done && req[i]) begin
				done     = 1'b1;
				pk.found = !blocked;
				pk.ch    = 4'(i);
			end
		end
		return pk;
	endfunction

endpackage

/* hdl/pic_core.sv */
// Next-state and result logic of the interrupt controller for one item.
module pic_core (
	input  pic_pkg::regfile_t rf,
	input  logic [7:0]        pins,
	input  logic [1:0]        mode,
	input  logic [4:0]        reg_index,
	input  logic [7:0]        write_data,
	input  logic [2:0]        pin_index,
	input  logic              pin_level,
	output pic_pkg::regfile_t rf_next,
	output logic [7:0]        pins_next,
	output pic_pkg::result_t  res
);

	always_comb begin
		logic [7:0]      d;
		logic            s_before;
		logic [15:0]     ipr16;
		logic [15:0]     isr16;
		logic [15:0]     ier16;
		logic [3:0]      ch;
		pic_pkg::pick_t  pk;
		pic_pkg::pick_t  pk_next;

		rf_next   = rf;
		pins_next = pins;
		res       = '0;
		d         = write_data;
		s_before  = rf[pic_pkg::R_VR][pic_pkg::VR_S_BIT];
		ipr16     = {rf[pic_pkg::R_IPRA], rf[pic_pkg::R_IPRB]};
		isr16     = {rf[pic_pkg::R_ISRA], rf[pic_pkg::R_ISRB]};
		ier16     = {rf[pic_pkg::R_IERA], rf[pic_pkg::R_IERB]};
		ch        = pic_pkg::pin_channel(pin_index);
		pk        = pic_pkg::pick_channel(rf);

		case (pic_pkg::mode_t'(mode))
			pic_pkg::MODE_WRITE: begin
				if ({1'b0, reg_index} < pic_pkg::REG_COUNT) begin
					// pending registers only accept cleared bits
					if (reg_index == pic_pkg::R_IPRA || reg_index == pic_pkg::R_IPRB) begin
						d = d & rf[reg_index];
					end
					rf_next[reg_index] = d;
					rf_next[pic_pkg::R_VR]    = rf_next[pic_pkg::R_VR] & 8'hF8;
					rf_next[pic_pkg::R_TACR]  = rf_next[pic_pkg::R_TACR] & 8'h0F;
					rf_next[pic_pkg::R_TBCR]  = rf_next[pic_pkg::R_TBCR] & 8'h0F;
					rf_next[pic_pkg::R_TCDCR] = rf_next[pic_pkg::R_TCDCR] & 8'h77;
					rf_next[pic_pkg::R_UCR]   = rf_next[pic_pkg::R_UCR] & 8'hFE;
					if (reg_index == pic_pkg::R_IERA || reg_index == pic_pkg::R_IERB) begin
						rf_next[pic_pkg::R_IPRA] = rf_next[pic_pkg::R_IPRA]
							& rf_next[pic_pkg::R_IERA];
						rf_next[pic_pkg::R_IPRB] = rf_next[pic_pkg::R_IPRB]
							& rf_next[pic_pkg::R_IERB];
					end else if (reg_index == pic_pkg::R_ISRA
							|| reg_index == pic_pkg::R_ISRB) begin
						if (!rf_next[pic_pkg::R_VR][pic_pkg::VR_S_BIT]) begin
							rf_next[pic_pkg::R_ISRA] = '0;
							rf_next[pic_pkg::R_ISRB] = '0;
						end
					end else if (reg_index == pic_pkg::R_VR) begin
						if (s_before && !rf_next[pic_pkg::R_VR][pic_pkg::VR_S_BIT]) begin
							rf_next[pic_pkg::R_ISRA] = '0;
							rf_next[pic_pkg::R_ISRB] = '0;
						end
					end
				end
			end
			pic_pkg::MODE_READ: begin
				if ({1'b0, reg_index} < pic_pkg::REG_COUNT) begin
					res.read_data = rf[reg_index];
				end
			end
			pic_pkg::MODE_ACK: begin
				if (pk.found) begin
					ipr16[pk.ch] = 1'b0;
					if (s_before) begin
						isr16[pk.ch] = 1'b1;
					end
					rf_next[pic_pkg::R_IPRA] = ipr16[15:8];
					rf_next[pic_pkg::R_IPRB] = ipr16[7:0];
					rf_next[pic_pkg::R_ISRA] = isr16[15:8];
					rf_next[pic_pkg::R_ISRB] = isr16[7:0];
					res.vector_out = {rf[pic_pkg::R_VR][7:4], pk.ch};
				end else begin
					res.spurious = 1'b1;
				end
			end
			pic_pkg::MODE_PIN: begin
				if (pins[pin_index] != pin_level) begin
					pins_next[pin_index] = pin_level;
					if (!rf[pic_pkg::R_DDR][pin_index]
							&& rf[pic_pkg::R_AER][pin_index] == pin_level
							&& ier16[ch]) begin
						ipr16[ch] = 1'b1;
						rf_next[pic_pkg::R_IPRA] = ipr16[15:8];
						rf_next[pic_pkg::R_IPRB] = ipr16[7:0];
					end
				end
			end
			default: begin
				rf_next = rf;
			end
		endcase

		pk_next         = pic_pkg::pick_channel(rf_next);
		res.irq_request = pk_next.found;
	end

endmodule

/* hdl/prioritized_interrupt_controller.sv */
// Top level of the 16-channel prioritized interrupt controller with output skid buffer.
//
// Usage: every input transfer is one bus or pin event. mode selects a register write,
// a register read, an interrupt acknowledge or an input pin level change; reg_index,
// write_data, pin_index and pin_level carry the operands. Every input transfer yields
// exactly one output transfer with read_data, vector_out, spurious and irq_request,
// where irq_request reflects the controller state after the event.
// The result is registered in the output register, or the skid register when held.
// Throughput: one item per cycle while in_ready is high; the register file update and
// the 16-channel priority encode sit between the state and output registers.
// Reset (arst_n low): all 24 registers and the pin level image clear to zero, no
// result is held, in_ready is high during and right after reset.
// Stall: when out_ready is low the result holds in the output register; one further
// input is still taken into a skid register, then in_ready drops until the output
// side drains. Results always leave in input order.
module prioritized_interrupt_controller (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [4:0] reg_index,
	input  logic [7:0] write_data,
	input  logic [2:0] pin_index,
	input  logic       pin_level,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic [7:0] vector_out,
	output logic       spurious,
	output logic       irq_request
);

	// Architectural state
	pic_pkg::regfile_t rf_q;
	logic [7:0]        pins_q;

	// Output register and skid stage
	pic_pkg::result_t  out_q;
	logic              out_valid_q;
	pic_pkg::result_t  skid_q;
	logic              skid_valid_q;

	pic_pkg::regfile_t rf_next;
	logic [7:0]        pins_next;
	pic_pkg::result_t  res;
	logic              in_xfer;
	logic              out_free;

	// Take input whenever the skid stage is empty
	assign in_ready = !skid_valid_q;
	assign in_xfer  = in_valid && in_ready;
	assign out_free = out_ready || !out_valid_q;

	pic_core u_core (
		.rf         (rf_q),
		.pins       (pins_q),
		.mode       (mode),
		.reg_index  (reg_index),
		.write_data (write_data),
		.pin_index  (pin_index),
		.pin_level  (pin_level),
		.rf_next    (rf_next),
		.pins_next  (pins_next),
		.res        (res)
	);

	// Commit the state change of each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_q   <= '0;
			pins_q <= '0;
		end else if (in_xfer) begin
			rf_q   <= rf_next;
			pins_q <= pins_next;
		end
	end

	// Advance results: skid first, then fresh result; park in skid when output is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_xfer;
			end
		end else if (in_xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_xfer) begin
				out_q <= res;
			end
		end else if (in_xfer) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = out_q.read_data;
	assign vector_out  = out_q.vector_out;
	assign spurious    = out_q.spurious;
	assign irq_request = out_q.irq_request;

	// A parked result implies the output register is occupied
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while output register is empty");

	// Low bits of the vector register stay hardwired to zero
	a_vr_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rf_q[pic_pkg::R_VR][2:0] == 3'b000)
		else $error("vector register low bits are not zero");

	// A spurious acknowledge never carries a vector
	a_spurious_no_vec: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.spurious) |-> (out_q.vector_out == 8'h00))
		else $error("spurious acknowledge with nonzero vector");

	// A write to pending register B can only clear bits
	a_ipr_write_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && mode == pic_pkg::MODE_WRITE && reg_index == pic_pkg::R_IPRB)
		|=> ((rf_q[pic_pkg::R_IPRB] & ~$past(rf_q[pic_pkg::R_IPRB])) == 8'h00))
		else $error("pending register write set a bit");

endmodule
